>>> hdl/array_priority_queue_defines.svh
// Assertion macros for the array priority queue.
// Depends on nothing; taken in by files that carry concurrent checks.
`ifndef ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define APQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apq: same-cycle check failed");
`define APQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apq: next-cycle check failed");
`else
`define APQ_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define APQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/apq_pkg.sv
// Shared types and constants for the array priority queue.
// Depends on nothing; used by the datapath, controller and top level.
package apq_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 8;
   localparam int OCC_W  = 8;
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

   typedef enum logic [1:0] {
      FUNC_ENQUEUE     = 2'd0,
      FUNC_DEQUEUE     = 2'd1,
      FUNC_PEEK_OLDEST = 2'd2,
      FUNC_PEEK_NEWEST = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      RES_OK_ZERO,
      RES_OVERFLOW,
      RES_EMPTY,
      RES_PEEK,
      RES_BEST
   } res_kind_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   localparam entry_type ENTRY_ZERO = '{data: '0, prio: '0};

   typedef struct packed {
      func_type                 func;
      logic signed [DATA_W-1:0] in_data;
      logic signed [DATA_W-1:0] in_priority;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_data;
      logic signed [DATA_W-1:0] out_priority;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic         load_req;
      logic         enq_write;
      logic         peek_front;
      logic         peek_rear;
      logic         scan_start;
      logic         scan_step;
      logic         shift_step;
      logic         count_dec;
      logic         res_load;
      res_kind_type res_kind;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     empty;
      logic     scan_last;
      logic     shift_done;
      logic     rsp_free;
   } stat_type;

endpackage

>>> hdl/array_priority_queue.sv
// Bounded min-first priority queue kept as an unsorted array in arrival order.
// Enqueue, an empty-queue operation, and both peeks each pass from dispatch
// straight to finish. A dequeue reads every held entry through the single read
// port of the entry RAM to find the minimum (earliest on ties), then moves each
// later entry down one place through the same port. A finished result sits in
// an output register, so the next item is taken while it waits. The entry RAM
// needs no clearing after reset; the count is cleared and the capacity reloaded.
`include "array_priority_queue_defines.svh"

module array_priority_queue #(
   parameter int DEPTH = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  apq_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output apq_pkg::rsp_type          rsp_payload,
   input  logic                      csr_we,
   input  logic [apq_pkg::CAP_W-1:0] csr_wdata
);

   apq_pkg::cmd_type  dp_cmd;
   apq_pkg::stat_type dp_stat;
   logic              rsp_err;
   logic              rsp_zero;
   logic              rsp_free;

   apq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   apq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   assign rsp_err  = rsp_valid && (rsp_payload.status != apq_pkg::STATUS_OK);
   assign rsp_zero = (rsp_payload.out_data == 0) && (rsp_payload.out_priority == 0);
   assign rsp_free = !rsp_valid || rsp_ready;

   `APQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `APQ_ASSERT_IMPLIES(a_no_result_overwrite, clock, reset, dp_cmd.res_load, rsp_free)
   `APQ_ASSERT_IMPLIES(a_error_zero_payload, clock, reset, rsp_err, rsp_zero)

endmodule

>>> hdl/apq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module apq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/apq_datapath.sv
// Datapath: entry RAM, count and capacity, minimum scan, tail shift, result register.
// Depends on apq_pkg and apq_ram; driven by apq_ctrl through cmd_type.
module apq_datapath #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  apq_pkg::cmd_type         cmd,
   output apq_pkg::stat_type        stat,
   input  apq_pkg::req_type         req_payload,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output apq_pkg::rsp_type         rsp_payload,
   input  logic                     csr_we,
   input  logic [apq_pkg::CAP_W-1:0] csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > apq_pkg::CAP_W) ? CW : apq_pkg::CAP_W;

   apq_pkg::req_type   req_ff;
   apq_pkg::entry_type best_ff, best_in;
   apq_pkg::rsp_type   rsp_ff, rsp_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic               pend_ff, pend_in;
   logic               scan_first_ff, scan_first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [apq_pkg::CAP_W-1:0] capacity_ff;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   apq_pkg::entry_type wr_data, rd_data;
   logic [LW-1:0]      cap_w, limit_w;
   logic               ptr_below;
   logic               take;

   apq_ram #(
      .WIDTH ($bits(apq_pkg::entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // capacity saturates at the built depth
   always_comb begin
      cap_w   = LW'(capacity_ff);
      limit_w = (cap_w > LW'(DEPTH)) ? LW'(DEPTH) : cap_w;
   end

   assign ptr_below = (ptr_ff < count_ff);
   assign take      = scan_first_ff || (rd_data.prio < best_ff.prio);

   always_comb begin
      stat.func       = req_ff.func;
      stat.full       = (LW'(count_ff) >= limit_w);
      stat.empty      = (count_ff == '0);
      stat.scan_last  = (cmp_idx_ff == AW'(count_ff - CW'(1)));
      stat.shift_done = !pend_ff && !ptr_below;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = '0;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      cmp_idx_in    = cmp_idx_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      scan_first_in = scan_first_ff;

      if (cmd.enq_write) begin
         wr_en        = 1'b1;
         wr_addr      = count_ff[AW-1:0];
         wr_data.data = req_ff.in_data;
         wr_data.prio = req_ff.in_priority;
         count_in     = count_ff + CW'(1);
      end

      if (cmd.peek_front) begin
         rd_en = 1'b1;
      end
      if (cmd.peek_rear) begin
         rd_en   = 1'b1;
         rd_addr = AW'(count_ff - CW'(1));
      end

      if (cmd.scan_start) begin
         rd_en         = 1'b1;
         ptr_in        = CW'(1);
         cmp_idx_in    = '0;
         scan_first_in = 1'b1;
         pend_in       = 1'b0;
      end

      if (cmd.scan_step) begin
         if (ptr_below) begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff[AW-1:0];
            ptr_in  = ptr_ff + CW'(1);
         end
         if (take) begin
            best_in     = rd_data;
            best_idx_in = cmp_idx_ff;
         end
         cmp_idx_in    = cmp_idx_ff + AW'(1);
         scan_first_in = 1'b0;
         // last compare: point the shift at the entry after the minimum
         if (stat.scan_last) begin
            ptr_in  = CW'(best_idx_in) + CW'(1);
            pend_in = 1'b0;
         end
      end

      if (cmd.shift_step) begin
         if (pend_ff) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_ff;
            wr_data = rd_data;
         end
         if (ptr_below) begin
            rd_en        = 1'b1;
            rd_addr      = ptr_ff[AW-1:0];
            ptr_in       = ptr_ff + CW'(1);
            pend_addr_in = AW'(ptr_ff - CW'(1));
            pend_in      = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in           = rsp_ff;
      rsp_in.occupancy = apq_pkg::OCC_W'(count_ff);
      case (cmd.res_kind)
         apq_pkg::RES_PEEK: begin
            rsp_in.out_data     = rd_data.data;
            rsp_in.out_priority = rd_data.prio;
            rsp_in.status       = apq_pkg::STATUS_OK;
         end
         apq_pkg::RES_BEST: begin
            rsp_in.out_data     = best_ff.data;
            rsp_in.out_priority = best_ff.prio;
            rsp_in.status       = apq_pkg::STATUS_OK;
         end
         apq_pkg::RES_OVERFLOW: begin
            rsp_in.out_data     = apq_pkg::ENTRY_ZERO.data;
            rsp_in.out_priority = apq_pkg::ENTRY_ZERO.prio;
            rsp_in.status       = apq_pkg::STATUS_OVERFLOW;
         end
         apq_pkg::RES_EMPTY: begin
            rsp_in.out_data     = apq_pkg::ENTRY_ZERO.data;
            rsp_in.out_priority = apq_pkg::ENTRY_ZERO.prio;
            rsp_in.status       = apq_pkg::STATUS_EMPTY;
         end
         default: begin
            rsp_in.out_data     = apq_pkg::ENTRY_ZERO.data;
            rsp_in.out_priority = apq_pkg::ENTRY_ZERO.prio;
            rsp_in.status       = apq_pkg::STATUS_OK;
         end
      endcase
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         capacity_ff   <= apq_pkg::CAP_RESET;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         scan_first_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
         scan_first_ff <= scan_first_in;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.res_load) begin
         rsp_ff <= rsp_in;
      end
      ptr_ff       <= ptr_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/apq_ctrl.sv
// Controller state machine: dispatch on the operation, sequence scan and shift.
// Depends on apq_pkg; drives apq_datapath through cmd_type.
module apq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  apq_pkg::stat_type stat,
   output apq_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DISPATCH = 5'b00010,
      ST_SCAN     = 5'b00100,
      ST_SHIFT    = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   apq_pkg::res_kind_type kind_ff, kind_in;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.res_kind = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_FINISH;
            if (stat.func == apq_pkg::FUNC_ENQUEUE) begin
               if (stat.full) begin
                  kind_in = apq_pkg::RES_OVERFLOW;
               end else begin
                  cmd.enq_write = 1'b1;
                  kind_in       = apq_pkg::RES_OK_ZERO;
               end
            end else if (stat.empty) begin
               kind_in = apq_pkg::RES_EMPTY;
            end else begin
               kind_in = apq_pkg::RES_PEEK;
               unique case (stat.func)
                  apq_pkg::FUNC_DEQUEUE: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  apq_pkg::FUNC_PEEK_OLDEST: cmd.peek_front = 1'b1;
                  default:                   cmd.peek_rear  = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               cmd.count_dec = 1'b1;
               kind_in       = apq_pkg::RES_BEST;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (stat.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= apq_pkg::RES_OK_ZERO;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !reset;

endmodule
